// ----- rtl/core/tnu_pkg.sv -----
// ----------------------------------------------------------------------------
// tnu_pkg: shared types of the text normalizer
// Item, result, state and result-buffer structs used by the step logic
// and the top level.
// ----------------------------------------------------------------------------
package tnu_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } out_t;

  typedef struct packed {
    logic [1:0][7:0] la_bytes;
    logic [1:0]      la_count;
    logic [7:0]      prev_byte;
    logic            have_prev;
    logic            skip_spaces;
  } state_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            fin;
    logic            marker;
  } res_t;

endpackage

// ----- rtl/core/tnu_step.sv -----
// ----------------------------------------------------------------------------
// tnu_step: per-byte normalization step
// Appends one byte to the lookahead, decides every byte that can be decided
// and returns the next state with up to three result bytes.
// ----------------------------------------------------------------------------
module tnu_step (
  input  tnu_pkg::state_t state_i,
  input  tnu_pkg::in_t    item_i,
  output tnu_pkg::state_t state_o,
  output tnu_pkg::res_t   res_o
);

  localparam logic [7:0] Space     = 8'h20;
  localparam logic [7:0] Hyphen    = 8'h2D;
  localparam logic [7:0] CaseShift = 8'd32;
  localparam logic [7:0] FwOffset  = 8'hE0;
  localparam logic [15:0] IdeoSpace = 16'h3000;
  localparam logic [15:0] FwLow     = 16'hFF01;
  localparam logic [15:0] FwHigh    = 16'hFF5E;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return is_upper(b) ? b + CaseShift : b;
  endfunction

  function automatic logic [7:0] map_single(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (is_upper(b)) begin
      r = b + CaseShift;
    end else if ((b == Space) || ((b >= 8'h07) && (b <= 8'h0D))) begin
      r = Space;
    end
    return r;
  endfunction

  always_comb begin
    logic [2:0][7:0] bb;
    logic [1:0]      n;
    logic [1:0]      p;
    logic [1:0]      rem;
    logic            stop;
    logic            fin;
    logic            skip;
    logic [7:0]      prev;
    logic            hp;
    logic [7:0]      h;
    logic [7:0]      nxt;
    logic            triple;
    logic            pass3;
    logic [15:0]     cp;
    logic [2:0][7:0] cand;
    logic [1:0]      cand_n;
    logic [2:0][7:0] em;
    logic [1:0]      ec;
    logic [1:0][7:0] left;

    fin    = item_i.is_final;
    bb[0]  = state_i.la_bytes[0];
    bb[1]  = state_i.la_bytes[1];
    bb[2]  = '0;
    n      = (state_i.la_count > 2'd2) ? 2'd2 : state_i.la_count;
    bb[n]  = item_i.text_byte;
    n      = n + 2'd1;
    p      = '0;
    stop   = 1'b0;
    skip   = state_i.skip_spaces;
    prev   = state_i.prev_byte;
    hp     = state_i.have_prev;
    em     = '0;
    ec     = '0;
    h      = '0;
    nxt    = '0;
    rem    = '0;
    triple = 1'b0;
    pass3  = 1'b0;
    cp     = '0;
    cand   = '0;
    cand_n = '0;

    for (int it = 0; it < 3; it++) begin
      if (!stop && (p < n)) begin
        h      = (p == 2'd0) ? bb[0] : ((p == 2'd1) ? bb[1] : bb[2]);
        nxt    = (p == 2'd0) ? bb[1] : bb[2];
        rem    = n - p;
        triple = 1'b0;
        pass3  = 1'b0;
        cand   = '0;
        cand_n = 2'd1;
        cp     = {h[3:0], bb[1][5:0], bb[2][5:0]};
        if (h[7:4] == 4'hE) begin
          if ((rem < 2'd3) && !fin) begin
            stop = 1'b1;
          end else if ((rem == 2'd3) && is_cont(bb[1]) && is_cont(bb[2])) begin
            triple = 1'b1;
            if (cp == IdeoSpace) begin
              cand[0] = Space;
            end else if ((cp >= FwLow) && (cp <= FwHigh)) begin
              cand[0] = lower(cp[7:0] - FwOffset);
            end else begin
              cand   = {bb[2], bb[1], bb[0]};
              cand_n = 2'd3;
              pass3  = 1'b1;
            end
          end else begin
            cand[0] = h;
          end
        end else if (h == Hyphen) begin
          if ((rem < 2'd2) && !fin) begin
            stop = 1'b1;
          end else if (hp && is_letter(prev) && (rem >= 2'd2) && is_letter(nxt)) begin
            cand_n = 2'd0;
          end else begin
            cand[0] = h;
          end
        end else begin
          cand[0] = map_single(h);
        end

        if (!stop) begin
          for (int j = 0; j < 3; j++) begin
            if ((2'(j) < cand_n) && !((cand[j] == Space) && skip)) begin
              if (cand[j] != Space) begin
                skip = 1'b0;
              end
              if (ec < 2'd3) begin
                em[ec] = cand[j];
                ec     = ec + 2'd1;
              end
            end
          end
          if (pass3) begin
            skip = 1'b1;
          end
          prev = triple ? bb[2] : h;
          hp   = 1'b1;
          p    = triple ? 2'd3 : p + 2'd1;
        end
      end
    end

    rem = n - p;
    case (p)
      2'd0:    left = {bb[1], bb[0]};
      2'd1:    left = {bb[2], bb[1]};
      2'd2:    left = {8'h00, bb[2]};
      default: left = '0;
    endcase

    state_o.la_bytes[0] = (rem > 2'd0) ? left[0] : '0;
    state_o.la_bytes[1] = (rem > 2'd1) ? left[1] : '0;
    state_o.la_count    = rem;
    state_o.prev_byte   = prev;
    state_o.have_prev   = hp;
    state_o.skip_spaces = skip;
    if (fin) begin
      state_o = '0;
    end

    res_o.bytes  = em;
    res_o.count  = ec;
    res_o.fin    = fin;
    res_o.marker = 1'b0;
    if (fin && (ec == 2'd0)) begin
      res_o.count  = 2'd1;
      res_o.marker = 1'b1;
    end
  end

endmodule

// ----- rtl/core/text_normalizer_utf8_fullwidth.sv -----
// ----------------------------------------------------------------------------
// text_normalizer_utf8_fullwidth: streaming byte normalizer
// Lowers ASCII, maps control bytes 07h-0Dh to space, drops hyphens between letters
// and folds three-byte UTF-8 ideographic space and fullwidth forms to ASCII.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while in_stall_o is low. Its results (zero
// to three bytes, or a bare end marker on a final byte that yields nothing)
// appear in the next cycle in a three-entry result buffer that drains one
// result per cycle while the receiver does not stall; a byte that gives
// several results stalls the input until its last result is taken, and with
// at most one result and no receiver stall the next byte enters in the next cycle.
// Three-byte lead bytes and hyphens wait in a two-byte lookahead until they can be
// decided; is_final flushes it and returns the stored state to its reset value.
module text_normalizer_utf8_fullwidth (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tnu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tnu_pkg::out_t out_data_o
);

  tnu_pkg::state_t state_q, state_d;
  tnu_pkg::res_t   res_q, res_d;
  logic            buf_valid_q, buf_valid_d;
  logic [1:0]      rd_q, rd_d;
  logic            in_accept;
  logic            out_pop;
  logic            last;
  logic            load;

  tnu_step u_step (
    .state_i (state_q),
    .item_i  (in_data_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign last        = rd_q == (res_q.count - 2'd1);
  assign out_valid_o = buf_valid_q;
  assign out_pop     = buf_valid_q && !out_stall_i;
  assign in_stall_o  = buf_valid_q && !(out_pop && last);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign load        = in_accept && (res_d.count != 2'd0);

  always_comb begin
    buf_valid_d = buf_valid_q;
    rd_d        = rd_q;
    if (load) begin
      buf_valid_d = 1'b1;
      rd_d        = '0;
    end else if (out_pop) begin
      if (last) begin
        buf_valid_d = 1'b0;
      end else begin
        rd_d = rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      buf_valid_q <= 1'b0;
      rd_q        <= '0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      buf_valid_q <= buf_valid_d;
      rd_q        <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    case (rd_q)
      2'd0:    out_data_o.out_byte = res_q.bytes[0];
      2'd1:    out_data_o.out_byte = res_q.bytes[1];
      2'd2:    out_data_o.out_byte = res_q.bytes[2];
      default: out_data_o.out_byte = '0;
    endcase
    if (res_q.marker) begin
      out_data_o.out_byte = '0;
    end
    out_data_o.byte_valid = !res_q.marker;
    out_data_o.run_last   = last;
    out_data_o.text_end   = res_q.fin && last;
  end

  a_rd_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (rd_q < res_q.count))
    else $error("result read index past buffered count");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.is_final) |=> (state_q == '0))
    else $error("state not cleared after final item");

  a_la_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.la_count != 2'd3)
    else $error("lookahead count out of range");

  a_marker_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_valid_q && res_q.marker) |-> ((res_q.count == 2'd1) && res_q.fin))
    else $error("end marker not a single final result");

endmodule

// ----- test/text_normalizer_utf8_fullwidth_test.sv -----
// ----------------------------------------------------------------------------
// text_normalizer_utf8_fullwidth_test: self-checking bench for the normalizer
// Sends directed texts and then random texts made of letters, hyphens, blanks,
// control bytes, three-byte UTF-8 sequences and noise. A predictor in the
// bench computes the normalized bytes of every accepted item, and a checker
// compares each result from the block against them in order. Sender and
// receiver stall at random in changing proportions.
// ----------------------------------------------------------------------------
module text_normalizer_utf8_fullwidth_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 100;
  localparam int REPORT_LIMIT = 10;

  localparam logic [7:0]  SPACE_CHAR    = 8'h20;
  localparam logic [7:0]  HYPHEN_CHAR   = 8'h2D;
  localparam logic [15:0] IDEO_SPACE_CP = 16'h3000;
  localparam logic [15:0] FW_FIRST_CP   = 16'hFF01;
  localparam logic [15:0] FW_LAST_CP    = 16'hFF5E;
  localparam logic [15:0] FW_TO_ASCII   = 16'hFEE0;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  tnu_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  tnu_pkg::out_t out_data_o;

  int send_idle_pct = 16;
  int recv_idle_pct = 78;
  int bytes_sent    = 0;
  int fail_count    = 0;
  int cycle_count   = 0;

  tnu_pkg::out_t expected_results[$];
  tnu_pkg::out_t want_result;
  logic [7:0]    text_q[$];
  logic [7:0]    step_bytes[$];

  logic [7:0] pend_bytes [2];
  int         pend_count;
  logic [7:0] last_in_byte;
  logic       have_last_in;
  logic       skip_blanks;

  text_normalizer_utf8_fullwidth dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_upper(logic [7:0] b);
    return b >= 8'h41 && b <= 8'h5A;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return is_upper(b) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic bit is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic void clear_normalizer_state();
    pend_bytes[0] = '0;
    pend_bytes[1] = '0;
    pend_count    = 0;
    last_in_byte  = '0;
    have_last_in  = 1'b0;
    skip_blanks   = 1'b0;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (b == SPACE_CHAR && skip_blanks) return;
    if (b != SPACE_CHAR) skip_blanks = 1'b0;
    step_bytes.push_back(b);
  endfunction

  function automatic void predict_normalized(tnu_pkg::in_t item);
    logic [7:0]    win [3];
    logic [7:0]    h;
    logic [7:0]    c;
    logic [15:0]   cp;
    logic [15:0]   diff;
    int            n;
    int            used;
    int            k;
    bit            held;
    bit            drop;
    tnu_pkg::out_t r;
    win[0] = pend_bytes[0];
    win[1] = pend_bytes[1];
    win[2] = '0;
    n = pend_count;
    win[n] = item.text_byte;
    n++;
    held = 1'b0;
    step_bytes.delete();
    while (n > 0 && !held) begin
      h = win[0];
      used = 1;
      if (h[7:4] == 4'hE && n < 3 && !item.is_final) begin
        held = 1'b1;
      end else if (h == HYPHEN_CHAR && n < 2 && !item.is_final) begin
        held = 1'b1;
      end else begin
        if (h[7:4] == 4'hE) begin
          if (n >= 3 && is_cont(win[1]) && is_cont(win[2])) begin
            used = 3;
            cp = {h[3:0], win[1][5:0], win[2][5:0]};
            if (cp == IDEO_SPACE_CP) begin
              put_byte(SPACE_CHAR);
            end else if (cp >= FW_FIRST_CP && cp <= FW_LAST_CP) begin
              diff = cp - FW_TO_ASCII;
              c = diff[7:0];
              if (is_upper(c)) c = c + 8'd32;
              put_byte(c);
            end else begin
              put_byte(win[0]);
              put_byte(win[1]);
              put_byte(win[2]);
              skip_blanks = 1'b1;
            end
          end else begin
            put_byte(h);
          end
        end else if (h == HYPHEN_CHAR) begin
          drop = have_last_in && is_letter(last_in_byte) && n >= 2 && is_letter(win[1]);
          if (!drop) put_byte(h);
        end else if (is_upper(h)) begin
          put_byte(h + 8'd32);
        end else if (h == SPACE_CHAR || (h >= 8'h07 && h <= 8'h0D)) begin
          put_byte(SPACE_CHAR);
        end else begin
          put_byte(h);
        end
        last_in_byte = win[used - 1];
        have_last_in = 1'b1;
        for (k = 0; k + used < n; k++) win[k] = win[k + used];
        n -= used;
      end
    end
    pend_bytes[0] = n > 0 ? win[0] : 8'h00;
    pend_bytes[1] = n > 1 ? win[1] : 8'h00;
    pend_count    = n;
    for (k = 0; k < step_bytes.size(); k++) begin
      r.out_byte   = step_bytes[k];
      r.byte_valid = 1'b1;
      r.run_last   = (k == step_bytes.size() - 1);
      r.text_end   = item.is_final && (k == step_bytes.size() - 1);
      expected_results.push_back(r);
    end
    if (item.is_final && step_bytes.size() == 0) begin
      r.out_byte   = 8'h00;
      r.byte_valid = 1'b0;
      r.run_last   = 1'b1;
      r.text_end   = 1'b1;
      expected_results.push_back(r);
    end
    if (item.is_final) clear_normalizer_state();
  endfunction

  task automatic send_item(input logic [7:0] b, input logic fin);
    tnu_pkg::in_t item;
    item.text_byte = b;
    item.is_final  = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_normalized(item);
    bytes_sent++;
  endtask

  task automatic send_queued_text();
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void build_random_text();
    int          tokens;
    int          reps;
    logic [15:0] cp;
    bit          triple;
    text_q.delete();
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      triple = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          reps = $urandom_range(1, 3);
          repeat (reps) begin
            if ($urandom_range(1)) text_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
            else text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
          end
        end
        3: text_q.push_back(HYPHEN_CHAR);
        4: text_q.push_back(8'h07 + 8'($urandom_range(0, 6)));
        5: begin
          reps = $urandom_range(1, 3);
          repeat (reps) text_q.push_back(SPACE_CHAR);
        end
        6: begin
          cp = IDEO_SPACE_CP;
          triple = 1'b1;
        end
        7: begin
          cp = 16'($urandom_range(16'hFF00, 16'hFF5F));
          triple = 1'b1;
        end
        8: begin
          cp = 16'($urandom);
          triple = 1'b1;
        end
        default: begin
          reps = $urandom_range(1, 2);
          repeat (reps) text_q.push_back(8'($urandom));
        end
      endcase
      if (triple) begin
        text_q.push_back({4'hE, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    end
  endfunction

  task automatic test_ascii_and_controls();
    text_q = '{8'h41, 8'h7A, 8'h00, 8'h07, 8'h0D, 8'h0E, 8'hFF};
    send_queued_text();
  endtask

  task automatic test_hyphens();
    text_q = '{HYPHEN_CHAR, 8'h61, HYPHEN_CHAR, 8'h5A, HYPHEN_CHAR};
    send_queued_text();
  endtask

  task automatic test_utf8_sequences();
    text_q = '{8'hEF, 8'hBC, 8'hA1, 8'hE4, 8'hB8, 8'h80, 8'hE3, 8'h80, 8'h80, SPACE_CHAR};
    send_queued_text();
    text_q = '{8'hE3, 8'h41, 8'hE3, 8'h80};
    send_queued_text();
  endtask

  task automatic test_random_text(input int send_pct, input int recv_pct, input bit pause_midway);
    int start;
    bit paused;
    start  = bytes_sent;
    paused = 1'b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      build_random_text();
      send_queued_text();
      if (pause_midway && !paused && bytes_sent - start >= RANDOM_ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: byte %h valid %b last %b end %b",
                   out_data_o.out_byte, out_data_o.byte_valid,
                   out_data_o.run_last, out_data_o.text_end);
      end else begin
        want_result = expected_results.pop_front();
        if (out_data_o.out_byte !== want_result.out_byte ||
            out_data_o.byte_valid !== want_result.byte_valid ||
            out_data_o.run_last !== want_result.run_last ||
            out_data_o.text_end !== want_result.text_end) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                     want_result.out_byte, want_result.byte_valid,
                     want_result.run_last, want_result.text_end,
                     out_data_o.out_byte, out_data_o.byte_valid,
                     out_data_o.run_last, out_data_o.text_end);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[text_normalizer_utf8_fullwidth] ERROR");
    $finish;
  end

  initial begin
    clear_normalizer_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii_and_controls();
    test_hyphens();
    test_utf8_sequences();
    test_random_text(16, 78, 1'b1);
    test_random_text(78, 16, 1'b0);
    test_random_text(0, 0, 1'b0);
    wait_for_results();
    repeat (8) @(posedge clk_i);
    fail_count += expected_results.size();
    if (fail_count == 0) begin
      $display("[text_normalizer_utf8_fullwidth] OK");
    end else begin
      $display("[text_normalizer_utf8_fullwidth] ERROR");
    end
    $finish;
  end

endmodule
